// ===== rtl/cts_pkg.sv =====
package cts_pkg;

  localparam int ACTION_W = 4;

  typedef enum logic [3:0] {
    ACT_CREATE    = 4'd0,
    ACT_DISPATCH  = 4'd1,
    ACT_COMPLETE  = 4'd2,
    ACT_TRANSFER  = 4'd3,
    ACT_CALL      = 4'd4,
    ACT_DELAY     = 4'd5,
    ACT_TICK      = 4'd6,
    ACT_INT_ENTER = 4'd7,
    ACT_INT_EXIT  = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    RES_OK         = 3'd0,
    RES_INVALID    = 3'd1,
    RES_NO_SLOT    = 3'd2,
    RES_STACK_FULL = 3'd3,
    RES_PEND_ISR   = 3'd4,
    RES_TIMEOUT    = 3'd5,
    RES_NOT_SIGNAL = 3'd6,
    RES_IDLE       = 3'd7
  } result_t;

  localparam logic [1:0] ST_READY        = 2'd0;
  localparam logic [1:0] ST_PEND         = 2'd1;
  localparam logic [1:0] ST_PEND_TIMEOUT = 2'd3;

  localparam logic [1:0] AT_FREE     = 2'd0;
  localparam logic [1:0] AT_READY    = 2'd1;
  localparam logic [1:0] AT_PEND     = 2'd2;
  localparam logic [1:0] AT_DETACHED = 2'd3;

  localparam logic [7:0] NEST_LIMIT = 8'd255;
  localparam logic [31:0] INF_DELAY_RESET = 32'hFFFF_FFFF;
  localparam logic [0:0] REG_INF_DELAY = 1'b0;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] routine_id;
    logic [31:0] routine_arg;
    logic [4:0]  stack_size;
    logic [31:0] delay_ticks;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  task_id;
    logic [15:0] run_routine;
    logic [31:0] run_arg;
    logic        task_freed;
  } response_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch request
    logic exec;      // main action step
    logic fetch;     // present frame read address
    logic finish;    // emit result
    logic tick_init;
    logic tick_step;
    logic tick_done;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic needs_read;
    logic tick_last;
  } dp_stat_t;

endpackage

// ===== rtl/cts_ram.sv =====
module cts_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/cts_ctrl.sv =====
module cts_ctrl import cts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_FETCH = 6'b000100,
    S_DONE  = 6'b001000,
    S_TICK  = 6'b010000,
    S_TEND  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_tick) begin
          cmd.tick_init = 1'b1;
          state_next = S_TICK;
        end else if (stat.needs_read) begin
          cmd.fetch = 1'b1;
          state_next = S_FETCH;
        end else begin
          cmd.exec = 1'b1;
          state_next = S_DONE;
        end
      end
      S_FETCH: begin
        cmd.exec = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_TICK: begin
        cmd.tick_step = 1'b1;
        if (stat.tick_last) begin
          state_next = S_TEND;
        end
      end
      S_TEND: begin
        cmd.tick_done = 1'b1;
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);
endmodule

// ===== rtl/cts_dp.sv =====
module cts_dp import cts_pkg::*; #(
  parameter int MAX_TASKS = 8,
  parameter int MAX_STACK = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  request_t  req,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  logic [31:0] inf_code,
  output logic      done,
  output response_t resp
);
  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int NW = $clog2(MAX_TASKS + 1);
  localparam int SW = (MAX_STACK > 1) ? $clog2(MAX_STACK) : 1;
  localparam int LW = $clog2(MAX_STACK + 1);
  localparam int AW = $clog2(MAX_TASKS * MAX_STACK);
  localparam logic [NW-1:0] NONE = NW'(MAX_TASKS);
  localparam logic [NW-1:0] FULL = NW'(MAX_TASKS);

  request_t r;
  logic [NW-1:0] free_next [MAX_TASKS];
  logic [NW-1:0] free_head;
  logic [TW-1:0] ready_fifo [MAX_TASKS];
  logic [TW-1:0] ready_head;
  logic [NW-1:0] ready_count;
  logic [TW-1:0] pend_links [MAX_TASKS];
  logic [NW-1:0] pend_count;
  logic [1:0]    task_status [MAX_TASKS];
  logic [1:0]    task_place [MAX_TASKS];
  logic [31:0]   task_delay [MAX_TASKS];
  logic [SW-1:0] stack_pointer [MAX_TASKS];
  logic [LW-1:0] stack_limit [MAX_TASKS];
  logic [TW-1:0] current_task;
  logic [7:0]    isr_nesting;
  logic          task_running;
  logic [SW-1:0] run_frame;
  logic [2:0]    status;
  logic [2:0]    tid;
  logic          freed;
  logic          out_read;
  logic [NW-1:0] tick_i, keep;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [47:0]   ram_wdata, ram_rdata;

  cts_ram #(.WIDTH(48), .DEPTH(MAX_TASKS * MAX_STACK)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  function automatic logic [AW-1:0] faddr(input logic [TW-1:0] t, input logic [SW-1:0] s);
    return AW'(t * MAX_STACK + s);
  endfunction

  logic [TW-1:0] cur, head_t, fh_t, tail_idx, pt;
  logic [NW:0]   tail_sum;
  logic [LW:0]   sp_plus;
  logic [31:0]   dnext;
  assign cur      = current_task;
  assign head_t   = ready_fifo[ready_head];
  assign fh_t     = free_head[TW-1:0];
  assign tail_sum = (NW+1)'(ready_head) + (NW+1)'(ready_count);
  assign tail_idx = (tail_sum >= (NW+1)'(MAX_TASKS)) ? TW'(tail_sum - (NW+1)'(MAX_TASKS))
                                                     : TW'(tail_sum);
  assign pt       = pend_links[tick_i[TW-1:0]];
  assign dnext    = task_delay[pt] - 32'd1;
  assign sp_plus  = (LW+1)'(stack_pointer[cur]) + (LW+1)'(1);

  assign stat.is_tick    = (r.action == ACT_TICK);
  assign stat.needs_read = (r.action == ACT_DISPATCH && !task_running && ready_count != '0)
                        || (r.action == ACT_COMPLETE && task_running
                            && task_place[cur] == AT_DETACHED);
  assign stat.tick_last  = (tick_i >= pend_count) || (tick_i == NW'(MAX_TASKS - 1))
                        || (tick_i + NW'(1) >= pend_count);

  // read address is set up in the fetch cycle; once a dispatch has run, hold
  // the running task's frame so the response still shows it
  always_comb begin
    if (r.action == ACT_DISPATCH && !out_read) begin
      ram_raddr = faddr(head_t, stack_pointer[head_t]);
    end else begin
      ram_raddr = faddr(cur, run_frame);
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = faddr(cur, stack_pointer[cur]);
    ram_wdata = {r.routine_id, r.routine_arg};
    if (cmd.exec) begin
      unique case (r.action)
        ACT_CREATE: begin
          ram_we = (r.routine_id != '0) && (r.stack_size != '0) && (free_head < NONE);
          ram_waddr = faddr(fh_t, '0);
        end
        ACT_TRANSFER: ram_we = task_running;
        ACT_CALL: begin
          ram_we = task_running && (sp_plus < (LW+1)'(stack_limit[cur]));
          ram_waddr = faddr(cur, SW'(sp_plus));
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        free_next[i]     <= NW'(i + 1);
        ready_fifo[i]    <= '0;
        pend_links[i]    <= '0;
        task_status[i]   <= ST_READY;
        task_place[i]    <= AT_FREE;
        task_delay[i]    <= '0;
        stack_pointer[i] <= '0;
        stack_limit[i]   <= '0;
      end
      free_head <= '0;
      ready_head <= '0;
      ready_count <= '0;
      pend_count <= '0;
      current_task <= '0;
      isr_nesting <= '0;
      task_running <= 1'b0;
      run_frame <= '0;
      tick_i <= '0;
      keep <= '0;
      out_read <= 1'b0;
      done <= 1'b0;
    end else begin
      if (cmd.capture) begin
        r <= req;
        status <= RES_OK;
        tid <= 3'(current_task);
        freed <= 1'b0;
        out_read <= 1'b0;
      end
      if (cmd.exec) begin
        unique case (r.action)
          ACT_CREATE: begin
            if (r.routine_id == '0 || r.stack_size == '0) begin
              status <= RES_INVALID;
            end else if (free_head >= NONE) begin
              status <= RES_NO_SLOT;
            end else begin
              free_head <= free_next[fh_t];
              stack_limit[fh_t] <= (32'(r.stack_size) > MAX_STACK)
                                   ? LW'(MAX_STACK) : LW'(r.stack_size);
              stack_pointer[fh_t] <= '0;
              task_delay[fh_t] <= '0;
              task_status[fh_t] <= ST_READY;
              task_place[fh_t] <= AT_READY;
              if (ready_count < FULL) begin
                ready_fifo[tail_idx] <= fh_t;
                ready_count <= ready_count + NW'(1);
              end
              tid <= 3'(fh_t);
            end
          end
          ACT_DISPATCH: begin
            if (task_running) begin
              status <= RES_INVALID;
            end else if (ready_count == '0) begin
              status <= RES_IDLE;
            end else begin
              ready_head <= (32'(ready_head) == MAX_TASKS - 1) ? '0 : ready_head + TW'(1);
              ready_count <= ready_count - NW'(1);
              task_place[head_t] <= AT_DETACHED;
              current_task <= head_t;
              task_running <= 1'b1;
              run_frame <= stack_pointer[head_t];
              tid <= 3'(head_t);
              out_read <= 1'b1;
            end
          end
          ACT_COMPLETE: begin
            if (!task_running) begin
              status <= RES_INVALID;
            end else begin
              task_running <= 1'b0;
              if (task_place[cur] == AT_DETACHED) begin
                if (ram_rdata[47:32] != '0 || stack_pointer[cur] != '0) begin
                  if (ram_rdata[47:32] == '0) begin
                    stack_pointer[cur] <= stack_pointer[cur] - SW'(1);
                  end
                  task_status[cur] <= ST_READY;
                  task_place[cur] <= AT_READY;
                  if (ready_count < FULL) begin
                    ready_fifo[tail_idx] <= cur;
                    ready_count <= ready_count + NW'(1);
                  end
                end else begin
                  free_next[cur] <= free_head;
                  free_head <= NW'(cur);
                  task_place[cur] <= AT_FREE;
                  freed <= 1'b1;
                end
              end
            end
          end
          ACT_TRANSFER: if (!task_running) status <= RES_INVALID;
          ACT_CALL: begin
            if (!task_running) begin
              status <= RES_INVALID;
            end else if (sp_plus >= (LW+1)'(stack_limit[cur])) begin
              status <= RES_STACK_FULL;
            end else begin
              stack_pointer[cur] <= SW'(sp_plus);
            end
          end
          ACT_DELAY: begin
            if (isr_nesting != '0) begin
              status <= RES_PEND_ISR;
            end else if (!task_running) begin
              status <= RES_INVALID;
            end else if (task_status[cur] == ST_READY) begin
              if (r.delay_ticks == '0) begin
                status <= RES_TIMEOUT;
              end else begin
                status <= RES_NOT_SIGNAL;
                if (task_place[cur] == AT_DETACHED && pend_count < FULL) begin
                  task_delay[cur] <= r.delay_ticks;
                  task_status[cur] <= ST_PEND;
                  task_place[cur] <= AT_PEND;
                  pend_links[pend_count[TW-1:0]] <= cur;
                  pend_count <= pend_count + NW'(1);
                end
              end
            end else if (task_status[cur] == ST_PEND) begin
              status <= RES_NOT_SIGNAL;
            end else begin
              task_status[cur] <= ST_READY;
              status <= RES_TIMEOUT;
            end
          end
          ACT_INT_ENTER: if (isr_nesting < NEST_LIMIT) isr_nesting <= isr_nesting + 8'd1;
          ACT_INT_EXIT:  if (isr_nesting != '0) isr_nesting <= isr_nesting - 8'd1;
          default: status <= RES_INVALID;
        endcase
      end
      if (cmd.tick_init) begin
        tick_i <= '0;
        keep <= '0;
      end
      // walk one pend entry per cycle, compacting survivors in place
      if (cmd.tick_step && tick_i < pend_count) begin
        tick_i <= tick_i + NW'(1);
        if (task_delay[pt] != '0 && task_delay[pt] != inf_code) begin
          task_delay[pt] <= dnext;
        end
        if (task_delay[pt] != '0 && task_delay[pt] != inf_code && dnext == '0) begin
          task_status[pt] <= ST_PEND_TIMEOUT;
          task_place[pt] <= AT_READY;
          if (ready_count < FULL) begin
            ready_fifo[tail_idx] <= pt;
            ready_count <= ready_count + NW'(1);
          end
        end else begin
          pend_links[keep[TW-1:0]] <= pt;
          keep <= keep + NW'(1);
        end
      end
      if (cmd.tick_done) begin
        pend_count <= keep;
      end
      done <= cmd.finish;
    end
  end

  always_comb begin
    resp.status = status;
    resp.task_id = tid;
    resp.task_freed = freed;
    resp.run_routine = out_read ? ram_rdata[47:32] : '0;
    resp.run_arg = out_read ? ram_rdata[31:0] : '0;
  end
endmodule

// ===== rtl/cooperative_task_scheduler_core.sv =====
// Cooperative task scheduler. Raise start with a request while busy is low;
// exactly one response follows, shown for one cycle with done high, and the
// receiver cannot stall it. A dispatch that finds a ready task and a complete
// of a detached task pass through an extra fetch state because the
// return-stack memory has a registered read; tick walks the pend list one
// entry a cycle. Register 0 at address 0 holds the infinite delay code.
module cooperative_task_scheduler_core import cts_pkg::*; #(
  parameter int MAX_TASKS = 8,
  parameter int MAX_STACK = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  request_t    request,
  output logic        done,
  output response_t   response,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic [31:0] inf_code;
  logic done_r;

  assign pready = 1'b1;
  assign prdata = inf_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      inf_code <= INF_DELAY_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == {REG_INF_DELAY, 1'b0}) begin
      inf_code <= pwdata;
    end
  end

  cts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  cts_dp #(.MAX_TASKS(MAX_TASKS), .MAX_STACK(MAX_STACK)) u_dp (
    .clk(clk), .rst(rst), .req(request), .cmd(cmd), .stat(stat),
    .inf_code(inf_code), .done(done_r), .resp(response)
  );

  assign done = done_r;
endmodule
